@@ rtl/c3rgba_pkg.sv @@
// ----------------------------------------------------------------------------
// c3rgba_pkg
// Shared types and constants of the interleaved 3x3 convolution filter.
// ----------------------------------------------------------------------------
package c3rgba_pkg;

    localparam int BYTE_W      = 8;
    localparam int TAPS        = 9;
    localparam int KROWS       = 3;
    localparam int COEFF_W     = 16;
    localparam int FRAC_BITS   = 12;
    localparam int PROD_W      = 24;
    localparam int ACC_W       = 28;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_W    = 13;
    localparam int HEIGHT_MAX  = 4096;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET   = WIDTH_REG_W'(1024);
    localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET  = HEIGHT_W'(1024);
    localparam logic [63:0]            COEFF03_RESET = 64'h0199_0199_0199_0199;
    localparam logic [63:0]            COEFF47_RESET = 64'h0199_0199_0199_0333;
    localparam logic [COEFF_W-1:0]     COEFF8_RESET  = COEFF_W'(409);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COEFF_0_3    = 3'd2,
        REG_COEFF_4_7    = 3'd3,
        REG_COEFF_8      = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] pixel_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] filtered_byte;
        logic              frame_last;
    } out_item_t;

    // what the position tracker knows about one item
    typedef struct packed {
        logic            res;
        logic            last;
        logic [TAPS-1:0] mask;
    } pos_flags_t;

    typedef struct packed {
        logic [BYTE_W-1:0] upper;
        logic [BYTE_W-1:0] middle;
    } line_pair_t;

    typedef logic [TAPS-1:0][BYTE_W-1:0]  tap_bytes_t;
    typedef logic [TAPS-1:0][COEFF_W-1:0] coeff_set_t;

    typedef struct packed {
        tap_bytes_t bytes;
        logic       last;
    } tap_set_t;

endpackage

@@ rtl/c3rgba_stream_if.sv @@
// ----------------------------------------------------------------------------
// c3rgba_stream_if
// Valid/ready stream channel carrying one packed item per transfer.
// ----------------------------------------------------------------------------
interface c3rgba_stream_if #(
    parameter type item_t = logic
) ();

    logic  valid;
    logic  ready;
    item_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

@@ rtl/c3rgba_ram.sv @@
// ----------------------------------------------------------------------------
// c3rgba_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module c3rgba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/c3rgba_pos.sv @@
// ----------------------------------------------------------------------------
// c3rgba_pos
// Stream position tracker: frame restart, window centre, edge masks.
// ----------------------------------------------------------------------------
module c3rgba_pos
    import c3rgba_pkg::*;
#(
    parameter int MAX_WIDTH_PIXELS = 1024,
    parameter int CHANNELS = 4,
    localparam int LINE_MAX = MAX_WIDTH_PIXELS * CHANNELS,
    localparam int LEN_W = $clog2(LINE_MAX + 1),
    localparam int COL_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [WIDTH_REG_W-1:0] image_width,
    input  logic [HEIGHT_W-1:0]    image_height,
    input  logic                   accept,
    output logic [COL_W-1:0]       col,
    output pos_flags_t             flags
);

    localparam logic [LEN_W-1:0] CH_L = LEN_W'(CHANNELS);

    logic [COL_W-1:0]    col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;

    logic [LEN_W-1:0]    w_eff, len, col_x, col0, col1, pc;
    logic [HEIGHT_W-1:0] h_eff, h_plus1, row0, pr;
    logic                restart, res, last;
    logic [KROWS-1:0]    row_ok, col_ok;

    always_comb
    begin
        if (image_width == '0)
            w_eff = LEN_W'(1);
        else if (32'(image_width) > 32'(MAX_WIDTH_PIXELS))
            w_eff = LEN_W'(MAX_WIDTH_PIXELS);
        else
            w_eff = LEN_W'(image_width);
        len = LEN_W'(w_eff * CH_L);

        if (image_height == '0)
            h_eff = HEIGHT_W'(1);
        else if (image_height > HEIGHT_W'(HEIGHT_MAX))
            h_eff = HEIGHT_W'(HEIGHT_MAX);
        else
            h_eff = image_height;
        h_plus1 = h_eff + HEIGHT_W'(1);

        // position off the current geometry: start the frame over
        col_x   = LEN_W'(col_reg);
        restart = (col_x >= len) || (row_reg > h_plus1) ||
                  ((row_reg == h_plus1) && (col_x >= CH_L));
        row0 = restart ? '0 : row_reg;
        col0 = restart ? '0 : col_x;

        res = (row0 >= HEIGHT_W'(2)) || ((row0 == HEIGHT_W'(1)) && (col0 >= CH_L));

        // centre lies one line plus one pixel behind
        if (col0 >= CH_L)
        begin
            pc = col0 - CH_L;
            pr = row0 - HEIGHT_W'(1);
        end
        else
        begin
            pc = col0 + len - CH_L;
            pr = row0 - HEIGHT_W'(2);
        end

        row_ok[0] = (pr != '0);
        row_ok[1] = (pr < h_eff);
        row_ok[2] = ({1'b0, pr} + (HEIGHT_W+1)'(1)) < {1'b0, h_eff};
        col_ok[0] = (pc >= CH_L);
        col_ok[1] = 1'b1;
        col_ok[2] = ({1'b0, pc} + {1'b0, CH_L}) < {1'b0, len};

        last = (pr == h_eff - HEIGHT_W'(1)) && (pc == len - LEN_W'(1));

        for (int r = 0; r < KROWS; r++)
        begin
            for (int c = 0; c < KROWS; c++)
            begin
                flags.mask[r*KROWS + c] = row_ok[r] && col_ok[c];
            end
        end
        flags.res  = res;
        flags.last = last;
        col        = COL_W'(col0);

        col1 = col0 + LEN_W'(1);
        if (res && last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col1 == len)
        begin
            col_next = '0;
            row_next = row0 + HEIGHT_W'(1);
        end
        else
        begin
            col_next = COL_W'(col1);
            row_next = row0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ rtl/c3rgba_window.sv @@
// ----------------------------------------------------------------------------
// c3rgba_window
// Line buffers and the 3-row tap window; picks the nine masked taps.
// ----------------------------------------------------------------------------
module c3rgba_window
    import c3rgba_pkg::*;
#(
    parameter int MAX_WIDTH_PIXELS = 1024,
    parameter int CHANNELS = 4,
    localparam int LINE_MAX = MAX_WIDTH_PIXELS * CHANNELS,
    localparam int COL_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
    localparam int SPAN = 2 * CHANNELS + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              kind,
    input  logic [BYTE_W-1:0] pixel_byte,
    input  logic [COL_W-1:0]  col,
    input  pos_flags_t        flags,
    output logic              ready,
    output logic              tap_valid,
    input  logic              tap_ready,
    output tap_set_t          taps
);

    localparam int PAIR_W = 2 * BYTE_W;

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic [COL_W-1:0]  s1_col_reg;
    pos_flags_t        s1_flags_reg;
    logic              fwd_reg;
    line_pair_t        fwd_data_reg;
    logic [BYTE_W-1:0] window_reg  [KROWS][SPAN];
    logic [BYTE_W-1:0] window_next [KROWS][SPAN];
    logic              s2_valid_reg;
    tap_set_t          s2_taps_reg;

    logic              stage2_free, leave1;
    logic [PAIR_W-1:0] ram_rdata;
    line_pair_t        pair_eff, pair_wr;
    tap_bytes_t        tap_sel;

    assign stage2_free = !s2_valid_reg || tap_ready;
    assign leave1      = s1_valid_reg && (!s1_flags_reg.res || stage2_free);
    assign ready       = !s1_valid_reg || leave1;

    // back-to-back access of one column: take the write still in flight
    assign pair_eff       = fwd_reg ? fwd_data_reg : line_pair_t'(ram_rdata);
    assign pair_wr.upper  = pair_eff.middle;
    assign pair_wr.middle = s1_byte_reg;

    c3rgba_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .clk   (clk),
        .we    (leave1),
        .waddr (s1_col_reg),
        .wdata (pair_wr),
        .re    (accept),
        .raddr (col),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int r = 0; r < KROWS; r++)
        begin
            for (int j = SPAN - 1; j > 0; j--)
            begin
                window_next[r][j] = window_reg[r][j-1];
            end
        end
        window_next[0][0] = pair_eff.upper;
        window_next[1][0] = pair_eff.middle;
        window_next[2][0] = s1_byte_reg;

        // right tap is the newest byte, left tap two pixels back
        for (int r = 0; r < KROWS; r++)
        begin
            for (int c = 0; c < KROWS; c++)
            begin
                tap_sel[r*KROWS + c] = s1_flags_reg.mask[r*KROWS + c] ?
                    window_next[r][(KROWS - 1 - c) * CHANNELS] : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            for (int r = 0; r < KROWS; r++)
            begin
                for (int j = 0; j < SPAN; j++)
                begin
                    window_reg[r][j] <= '0;
                end
            end
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= leave1 && (col == s1_col_reg);
            end
            else if (leave1)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (leave1)
            begin
                window_reg <= window_next;
            end

            if (leave1 && s1_flags_reg.res)
                s2_valid_reg <= 1'b1;
            else if (tap_ready)
                s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg  <= kind ? '0 : pixel_byte;
            s1_col_reg   <= col;
            s1_flags_reg <= flags;
            fwd_data_reg <= pair_wr;
        end
        if (leave1 && s1_flags_reg.res)
        begin
            s2_taps_reg.bytes <= tap_sel;
            s2_taps_reg.last  <= s1_flags_reg.last;
        end
    end

    assign tap_valid = s2_valid_reg;
    assign taps      = s2_taps_reg;

endmodule

@@ rtl/c3rgba_mac.sv @@
// ----------------------------------------------------------------------------
// c3rgba_mac
// Nine products, two-level sum, truncation toward zero, result register.
// ----------------------------------------------------------------------------
module c3rgba_mac
    import c3rgba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tap_valid,
    output logic       tap_ready,
    input  tap_set_t   taps,
    input  coeff_set_t coeffs,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);

    localparam int GROUPS = TAPS / KROWS;
    localparam logic [ACC_W-1:0] TRUNC_BIAS = ACC_W'((1 << FRAC_BITS) - 1);

    logic                     s3_valid_reg, s4_valid_reg, s5_valid_reg, out_valid_reg;
    logic signed [PROD_W-1:0] s3_prod_reg [TAPS];
    logic signed [PROD_W-1:0] prod_next   [TAPS];
    logic                     s3_last_reg, s4_last_reg, s5_last_reg;
    logic signed [ACC_W-1:0]  s4_part_reg [GROUPS];
    logic signed [ACC_W-1:0]  part_next   [GROUPS];
    logic signed [ACC_W-1:0]  s5_acc_reg, acc_next;
    out_item_t                out_item_reg, out_item_next;

    logic signed [PROD_W-1:0] coeff_ext, byte_ext;
    logic [ACC_W-1:0]         biased;
    logic                     out_free, s5_free, s4_free, s3_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign s5_free   = !s5_valid_reg || out_free;
    assign s4_free   = !s4_valid_reg || s5_free;
    assign s3_free   = !s3_valid_reg || s4_free;
    assign tap_ready = s3_free;

    always_comb
    begin
        coeff_ext = '0;
        byte_ext  = '0;
        for (int t = 0; t < TAPS; t++)
        begin
            coeff_ext    = PROD_W'($signed(coeffs[t]));
            byte_ext     = PROD_W'($signed({1'b0, taps.bytes[t]}));
            prod_next[t] = coeff_ext * byte_ext;
        end

        for (int g = 0; g < GROUPS; g++)
        begin
            part_next[g] = ACC_W'(s3_prod_reg[g*KROWS])
                         + ACC_W'(s3_prod_reg[g*KROWS + 1])
                         + ACC_W'(s3_prod_reg[g*KROWS + 2]);
        end

        acc_next = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            acc_next = acc_next + s4_part_reg[g];
        end

        // negative sums get the bias so the shift truncates toward zero
        biased = s5_acc_reg + (s5_acc_reg[ACC_W-1] ? TRUNC_BIAS : '0);
        out_item_next.filtered_byte = biased[FRAC_BITS +: BYTE_W];
        out_item_next.frame_last    = s5_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_free)
                s3_valid_reg <= tap_valid;
            if (s4_free)
                s4_valid_reg <= s3_valid_reg;
            if (s5_free)
                s5_valid_reg <= s4_valid_reg;
            if (out_free)
                out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_free && tap_valid)
        begin
            s3_prod_reg <= prod_next;
            s3_last_reg <= taps.last;
        end
        if (s4_free && s3_valid_reg)
        begin
            s4_part_reg <= part_next;
            s4_last_reg <= s3_last_reg;
        end
        if (s5_free && s4_valid_reg)
        begin
            s5_acc_reg  <= acc_next;
            s5_last_reg <= s4_last_reg;
        end
        if (out_free && s5_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ rtl/conv3x3_interleaved_rgba_filter_top.sv @@
// ----------------------------------------------------------------------------
// conv3x3_interleaved_rgba_filter_top
// 3x3 convolution over interleaved multi-channel bytes in raster order.
// ----------------------------------------------------------------------------
// usage
//   pixel_stream carries one channel byte per item (kind = 1 is a flush item,
//   read as a zero byte). result_stream carries one filtered byte per window
//   centre, frame_last marks the last byte of the frame. each channel is
//   filtered on its own; taps are signed Q4.12 from the register port.
//   the result for a centre appears once the byte one line plus one pixel
//   later has been taken, so the last line is drained with flush items.
//   throughput: one item per clock while result_stream is not stalled.
//   result_stream.valid rises once the item completing a window has passed
//   tap select, products, partial sums, final sum and truncation into the
//   result register; the input register and the line ram read share the
//   accepting edge. the line buffers are one ram of 2 bytes x line length,
//   read and written once per item; a column touched on consecutive items
//   is forwarded. reset clears the position and the window; line buffers start
//   undefined and are never read outside the image. while result_stream
//   stalls, items that give no result still flow in and the pipeline stages
//   fill before pixel_stream.ready drops. registers must be written only
//   while idle, which the user ensures; the block does not enforce it.
// ----------------------------------------------------------------------------
module conv3x3_interleaved_rgba_filter_top
    import c3rgba_pkg::*;
#(
    parameter int MAX_WIDTH_PIXELS = 1024,
    parameter int CHANNELS = 4,
    localparam int LINE_MAX = MAX_WIDTH_PIXELS * CHANNELS,
    localparam int COL_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    c3rgba_stream_if.sink          pixel_stream,
    c3rgba_stream_if.source        result_stream
);

    logic [WIDTH_REG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    logic [63:0]            coeff03_reg, coeff47_reg;
    logic [COEFF_W-1:0]     coeff8_reg;

    coeff_set_t        coeffs;
    logic              accept, in_ready;
    logic [COL_W-1:0]  col;
    pos_flags_t        flags;
    logic              tap_valid, tap_ready;
    tap_set_t          taps;
    out_item_t         out_item;
    logic              out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            coeff03_reg <= COEFF03_RESET;
            coeff47_reg <= COEFF47_RESET;
            coeff8_reg  <= COEFF8_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg   <= cfg_wr_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg  <= cfg_wr_data[HEIGHT_W-1:0];
                REG_COEFF_0_3:    coeff03_reg <= cfg_wr_data;
                REG_COEFF_4_7:    coeff47_reg <= cfg_wr_data;
                REG_COEFF_8:      coeff8_reg  <= cfg_wr_data[COEFF_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        for (int t = 0; t < 4; t++)
        begin
            coeffs[t]     = coeff03_reg[COEFF_W*t +: COEFF_W];
            coeffs[t + 4] = coeff47_reg[COEFF_W*t +: COEFF_W];
        end
        coeffs[TAPS-1] = coeff8_reg;
    end

    assign accept             = pixel_stream.valid && in_ready;
    assign pixel_stream.ready = in_ready;

    c3rgba_pos #(
        .MAX_WIDTH_PIXELS (MAX_WIDTH_PIXELS),
        .CHANNELS         (CHANNELS)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .accept       (accept),
        .col          (col),
        .flags        (flags)
    );

    c3rgba_window #(
        .MAX_WIDTH_PIXELS (MAX_WIDTH_PIXELS),
        .CHANNELS         (CHANNELS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (pixel_stream.payload.kind),
        .pixel_byte (pixel_stream.payload.pixel_byte),
        .col        (col),
        .flags      (flags),
        .ready      (in_ready),
        .tap_valid  (tap_valid),
        .tap_ready  (tap_ready),
        .taps       (taps)
    );

    c3rgba_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_valid (tap_valid),
        .tap_ready (tap_ready),
        .taps      (taps),
        .coeffs    (coeffs),
        .out_valid (out_valid),
        .out_ready (result_stream.ready),
        .out_item  (out_item)
    );

    assign result_stream.valid   = out_valid;
    assign result_stream.payload = out_item;

endmodule

@@ rtl/c3rgba_checker.sv @@
// ----------------------------------------------------------------------------
// c3rgba_checker
// Port-level checks of the convolution filter, bound to the top level.
// ----------------------------------------------------------------------------
module c3rgba_checker
    import c3rgba_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] filtered_byte,
    input logic              frame_last
);

    logic [31:0] in_count_reg;
    logic [31:0] out_count_reg;

    // items taken and results given since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready && !(&in_count_reg))
                in_count_reg <= in_count_reg + 32'd1;
            if (out_valid && out_ready && !(&out_count_reg))
                out_count_reg <= out_count_reg + 32'd1;
        end
    end

    a_out_valid_hold : assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
    ) else $error("result dropped while stalled");

    a_out_payload_hold : assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(filtered_byte) && $stable(frame_last)
    ) else $error("result changed while stalled");

    // a free result register lets the whole pipeline move
    a_ready_when_free : assert property (
        @(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready
    ) else $error("input stalled with free result register");

    a_result_has_item : assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> (out_count_reg < in_count_reg) || (&in_count_reg)
    ) else $error("result without a matching item");

endmodule

bind conv3x3_interleaved_rgba_filter_top c3rgba_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pixel_stream.valid),
    .in_ready      (pixel_stream.ready),
    .out_valid     (result_stream.valid),
    .out_ready     (result_stream.ready),
    .filtered_byte (result_stream.payload.filtered_byte),
    .frame_last    (result_stream.payload.frame_last)
);

@@ sim/conv3x3_filter_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv3x3_filter_checker
// Watches the register port and both streams of the interleaved 3x3 filter,
// predicts every filtered byte from its own copy of the line buffers, window
// and position, and compares each result field by field, oldest first.
// ----------------------------------------------------------------------------
module conv3x3_filter_checker
    import c3rgba_pkg::*;
#(
    parameter int MAX_WIDTH_PIXELS = 1024,
    parameter int CHANNELS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   pixel_valid,
    input  logic                   pixel_ready,
    input  in_item_t               pixel_item,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  out_item_t              result_item,
    output int                     fail_count,
    output int                     outstanding
);

    localparam int LINE_MAX = MAX_WIDTH_PIXELS * CHANNELS;
    localparam int SPAN = 2 * CHANNELS + 1;

    // predicted geometry and kernel
    logic [WIDTH_REG_W-1:0] width_cfg;
    logic [HEIGHT_W-1:0]    height_cfg;
    logic [63:0]            taps_lo;
    logic [63:0]            taps_hi;
    logic [COEFF_W-1:0]     tap_last;

    // predicted storage and stream position
    logic [BYTE_W-1:0] upper_row_buf [LINE_MAX];
    logic [BYTE_W-1:0] middle_row_buf [LINE_MAX];
    logic [BYTE_W-1:0] win_bytes [KROWS][SPAN];
    int                pos_row;
    int                pos_col;

    out_item_t filtered_q [$];
    int        fail_total = 0;

    function automatic longint tap_coeff(input int t);
        logic signed [COEFF_W-1:0] raw;
        if (t < 4)
            raw = taps_lo[16*t +: 16];
        else if (t < 8)
            raw = taps_hi[16*(t-4) +: 16];
        else
            raw = tap_last;
        return longint'(raw);
    endfunction

    task automatic convolve_item(input in_item_t it, output bit has_res, output out_item_t res);
        longint            w, h, len, lim, q, p, pr, pc, rr, cc, acc, quo;
        int                ic;
        logic [BYTE_W-1:0] v, up, mid;
        w = width_cfg;
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH_PIXELS)
            w = MAX_WIDTH_PIXELS;
        h = height_cfg;
        if (h == 0)
            h = 1;
        if (h > HEIGHT_MAX)
            h = HEIGHT_MAX;
        len = w * CHANNELS;
        lim = len * (h + 1) + CHANNELS - 1;

        // geometry shrank under the current position: start the frame over
        if (pos_col >= len || pos_row * len + pos_col > lim)
        begin
            pos_row = 0;
            pos_col = 0;
        end

        v = it.kind ? '0 : it.pixel_byte;
        ic = pos_col;
        up = upper_row_buf[ic];
        mid = middle_row_buf[ic];
        upper_row_buf[ic] = mid;
        middle_row_buf[ic] = v;
        for (int r = 0; r < KROWS; r++)
        begin
            for (int j = SPAN - 1; j > 0; j--)
                win_bytes[r][j] = win_bytes[r][j-1];
        end
        win_bytes[0][0] = up;
        win_bytes[1][0] = mid;
        win_bytes[2][0] = v;

        q = pos_row * len + ic;
        has_res = 1'b0;
        res = '0;
        if (q >= len + CHANNELS)
        begin
            p = q - len - CHANNELS;
            pr = p / len;
            pc = p % len;
            acc = 0;
            for (int dr = -1; dr <= 1; dr++)
            begin
                rr = pr + dr;
                if (rr >= 0 && rr < h)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        cc = pc + dc * CHANNELS;
                        if (cc >= 0 && cc < len)
                            acc += tap_coeff((dr + 1) * 3 + dc + 1) *
                                   longint'(win_bytes[dr+1][(1 - dc) * CHANNELS]);
                    end
                end
            end
            // signed division truncates toward zero, then keep the low byte
            quo = acc / 4096;
            res.filtered_byte = quo[BYTE_W-1:0];
            res.frame_last = (p == len * h - 1);
            has_res = 1'b1;
        end

        if (has_res && res.frame_last)
        begin
            pos_row = 0;
            pos_col = 0;
        end
        else
        begin
            ic++;
            if (ic >= len)
            begin
                ic = 0;
                pos_row++;
            end
            pos_col = ic;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        bit        has_res;
        out_item_t want;
        out_item_t pred;
        if (!rst_n)
        begin
            width_cfg = WIDTH_RESET;
            height_cfg = HEIGHT_RESET;
            taps_lo = COEFF03_RESET;
            taps_hi = COEFF47_RESET;
            tap_last = COEFF8_RESET;
            for (int i = 0; i < LINE_MAX; i++)
            begin
                upper_row_buf[i] = '0;
                middle_row_buf[i] = '0;
            end
            for (int r = 0; r < KROWS; r++)
            begin
                for (int j = 0; j < SPAN; j++)
                    win_bytes[r][j] = '0;
            end
            pos_row = 0;
            pos_col = 0;
            filtered_q.delete();
            outstanding <= 0;
            fail_count <= fail_total;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    if (fail_total < 10)
                        $display("%0t: result item with nothing pending: byte %02h last %0b",
                                 $realtime, result_item.filtered_byte, result_item.frame_last);
                    fail_total++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (result_item.filtered_byte !== want.filtered_byte ||
                        result_item.frame_last !== want.frame_last)
                    begin
                        if (fail_total < 10)
                            $display("%0t: mismatch: byte %02h last %0b, expected byte %02h last %0b",
                                     $realtime, result_item.filtered_byte, result_item.frame_last,
                                     want.filtered_byte, want.frame_last);
                        fail_total++;
                    end
                end
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_cfg = cfg_wr_data[WIDTH_REG_W-1:0];
                    REG_IMAGE_HEIGHT: height_cfg = cfg_wr_data[HEIGHT_W-1:0];
                    REG_COEFF_0_3:    taps_lo = cfg_wr_data;
                    REG_COEFF_4_7:    taps_hi = cfg_wr_data;
                    REG_COEFF_8:      tap_last = cfg_wr_data[COEFF_W-1:0];
                    default: ;
                endcase
            end

            if (pixel_valid && pixel_ready)
            begin
                convolve_item(pixel_item, has_res, pred);
                if (has_res)
                    filtered_q.push_back(pred);
            end

            outstanding <= filtered_q.size();
            fail_count <= fail_total;
        end
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the interleaved 3x3 filter with framed byte streams: extreme kernels
// and geometries first, then random frames, partial frames and noisy frames
// over changing registers, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
    import c3rgba_pkg::*;

    localparam int     MAX_WIDTH_PIXELS = 1024;
    localparam int     CHANNELS = 4;
    localparam int     CYCLE_NS = 12;
    localparam longint TIMEOUT_CYCLES = 4_000_000;
    localparam int     SETTLE_CYCLES = 20;
    localparam int     RANDOM_ITEMS = 1150;
    localparam int     CALM_TAIL = 200;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    int                     idle_rate = 0;
    int                     fail_count;
    int                     outstanding;

    c3rgba_stream_if #(.item_t(in_item_t))  pixel_if ();
    c3rgba_stream_if #(.item_t(out_item_t)) result_if ();

    conv3x3_interleaved_rgba_filter_top #(
        .MAX_WIDTH_PIXELS (MAX_WIDTH_PIXELS),
        .CHANNELS         (CHANNELS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .pixel_stream  (pixel_if),
        .result_stream (result_if)
    );

    conv3x3_filter_checker #(
        .MAX_WIDTH_PIXELS (MAX_WIDTH_PIXELS),
        .CHANNELS         (CHANNELS)
    ) check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .pixel_valid  (pixel_if.valid),
        .pixel_ready  (pixel_if.ready),
        .pixel_item   (pixel_if.payload),
        .result_valid (result_if.valid),
        .result_ready (result_if.ready),
        .result_item  (result_if.payload),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always #(CYCLE_NS / 2) clk = ~clk;

    function automatic int line_len(input int w);
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH_PIXELS)
            w = MAX_WIDTH_PIXELS;
        return w * CHANNELS;
    endfunction

    function automatic int rows_of(input int h);
        if (h == 0)
            h = 1;
        if (h > HEIGHT_MAX)
            h = HEIGHT_MAX;
        return h;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic logic [COEFF_W-1:0] pick_tap();
        int v;
        case ($urandom_range(0, 7))
            0:       v = 32'h7FFF;
            1:       v = 32'h8000;
            2, 3:    v = $urandom;
            default: v = int'($urandom_range(0, 12288)) - 6144;
        endcase
        return v[COEFF_W-1:0];
    endfunction

    function automatic logic [63:0] random_taps();
        return {pick_tap(), pick_tap(), pick_tap(), pick_tap()};
    endfunction

    task automatic send_item(input logic kind, input logic [BYTE_W-1:0] b);
        if ($urandom_range(0, 15) < idle_rate)
        begin
            pixel_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        pixel_if.valid <= 1'b1;
        pixel_if.payload <= '{kind: kind, pixel_byte: b};
        @(posedge clk);
        while (!pixel_if.ready)
            @(posedge clk);
    endtask

    // image region gets the odd flush item, the tail is mostly flush
    task automatic send_stream(input int image_items, input int count, input int flush_odds);
        for (int i = 0; i < count; i++)
        begin
            if (i < image_items)
                send_item($urandom_range(0, 15) < flush_odds, pick_byte());
            else
                send_item($urandom_range(0, 3) != 0, pick_byte());
        end
    endtask

    task automatic wait_idle();
        pixel_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        // items that give no result may still be in the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic [WIDTH_REG_W-1:0] w, input logic [HEIGHT_W-1:0] h,
                             input logic [63:0] lo, input logic [63:0] hi,
                             input logic [COEFF_W-1:0] last);
        logic [63:0] junk;
        wait_idle();
        junk = {$urandom, $urandom};
        cfg_wr_en <= 1'b1;
        put_reg(REG_IMAGE_WIDTH, {junk[63:WIDTH_REG_W], w});
        put_reg(REG_IMAGE_HEIGHT, {junk[63:HEIGHT_W], h});
        put_reg(REG_COEFF_0_3, lo);
        put_reg(REG_COEFF_4_7, hi);
        put_reg(REG_COEFF_8, {junk[63:COEFF_W], last});
        cfg_wr_en <= 1'b0;
    endtask

    // receiver stalls in random bursts
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else if ($urandom_range(0, 15) < idle_rate)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int                     random_items;
        int                     lb;
        int                     rh;
        int                     frame;
        int                     mode;
        int                     n;
        logic [WIDTH_REG_W-1:0] w;
        logic [HEIGHT_W-1:0]    h;
        random_items = 0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_wr_data = '0;
        pixel_if.valid = 1'b0;
        pixel_if.payload = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry and kernel, part of a first line
        idle_rate = 1;
        send_stream(200, 200, 1);

        // identity kernel on a single pixel, flush inside and bytes past the end
        idle_rate = 2;
        configure('0, '0, '0, 64'h0000_0000_0000_1000, '0);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'hA5);
        send_item(1'b0, 8'h80);
        send_item(1'b0, 8'h7F);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'hFF);
        send_item(1'b1, 8'h5A);
        send_item(1'b0, 8'h01);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'h00);

        // largest positive taps on saturated bytes, the result byte wraps
        configure(WIDTH_REG_W'(2), HEIGHT_W'(2), {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF);
        for (int i = 0; i < 28; i++)
            send_item(i >= 16, 8'hFF);

        // widest line, width and height registers clamped, cut short
        configure('1, '0, random_taps(), random_taps(), pick_tap());
        send_stream(160, 160, 1);

        // tallest frame on a one pixel line, first rows only
        configure('0, '1, random_taps(), random_taps(), pick_tap());
        send_stream(200, 200, 1);

        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= RANDOM_ITEMS - CALM_TAIL)
                idle_rate = 0;
            else
                idle_rate = $urandom_range(0, 4);
            if ($urandom_range(0, 7) != 0)
                w = WIDTH_REG_W'($urandom_range(1, 6));
            else
                w = WIDTH_REG_W'($urandom_range(0, 16));
            h = HEIGHT_W'($urandom_range(0, 6));
            configure(w, h, random_taps(), random_taps(), pick_tap());
            lb = line_len(w);
            rh = rows_of(h);
            frame = lb * (rh + 1) + CHANNELS;
            mode = $urandom_range(0, 9);
            if (mode <= 5)
            begin
                // back to back frames
                repeat ($urandom_range(1, 3))
                begin
                    send_stream(lb * rh, frame, 1);
                    random_items += frame;
                end
            end
            else if (mode <= 7)
            begin
                // cut short, the next geometry restarts or continues it
                n = $urandom_range(1, frame - 1);
                send_stream(lb * rh, n, 1);
                random_items += n;
            end
            else if (mode == 8)
            begin
                send_stream(lb * rh, frame, 7);
                random_items += frame;
            end
            else
            begin
                n = frame + $urandom_range(1, lb);
                send_stream(lb * rh, n, 1);
                random_items += n;
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("conv3x3_interleaved_rgba_filter_top verification clean");
        else
            $display("conv3x3_interleaved_rgba_filter_top verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #(CYCLE_NS * TIMEOUT_CYCLES);
        $display("conv3x3_interleaved_rgba_filter_top verification failed");
        $finish;
    end

endmodule
